### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file i2cra_checker.sv.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHK_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("check failed");

// The consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("check failed");

`endif

### hw/rtl/i2cra_pkg.sv
// Types, codes and constants of the I2C register access master.
// Used by i2cra_core and i2c_register_access_master; no dependencies.
package i2cra_pkg;

	localparam int MAX_BURST = 8;
	localparam int BURST_W   = $clog2(MAX_BURST + 1);

	typedef logic [BURST_W-1:0] burst_t;

	localparam logic [6:0] DEV_ADDR_RESET = 7'd83;
	localparam logic [3:0] DATA_BITS      = 4'd8;

	localparam logic [1:0] FUNC_WRITE = 2'd0;
	localparam logic [1:0] FUNC_READ  = 2'd1;
	localparam logic [1:0] FUNC_BURST = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE      = 5'd0,
		ST_START     = 5'd1,
		ST_RESTART   = 5'd2,
		ST_TX_ADDR_W = 5'd3,
		ST_TX_REG    = 5'd4,
		ST_TX_DATA   = 5'd5,
		ST_TX_ADDR_R = 5'd6,
		ST_RX        = 5'd7,
		ST_STOP      = 5'd8
	} step_t;

	typedef struct packed {
		logic       cmd_valid;
		logic [1:0] func;
		logic [7:0] reg_addr;
		logic [7:0] write_data;
		logic [3:0] burst_count;
		logic       sda_sample;
	} tick_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_pull_low;
		logic       busy_res;
		logic       read_valid;
		logic [7:0] read_data;
		logic       read_last;
		logic       nak_seen;
	} res_t;

endpackage

### hw/rtl/i2c_register_access_master.sv
// Top level of the I2C register access master.
// Depends on i2cra_pkg and i2cra_core.
//
// Usage: every input item is one bus phase tick from a prescaler. It carries
// a command offer (cmd_valid, func, reg_addr, write_data, burst_count), taken
// only while no command is running, and the sampled SDA level. For each input
// item the block returns exactly one output item with the SCL and SDA pin
// levels to drive for that tick, busy_res, a received byte with read_valid and
// read_last, and the sticky NAK flag of the current or last command.
// The output item comes in the cycle after input accept; one item per
// cycle is sustained, set by the single step of the sequencer state between
// the input and the output register. The output register lets a new item in
// whenever it is empty or being taken in the same cycle; while the receiver
// stalls, in_ready drops and the sequencer holds its state.
// The target address is written on the cfg channel, which is always ready;
// it must only be written while the block is idle.
// Reset clears the sequencer to idle, empties the output register and sets
// the target address to 83.
module i2c_register_access_master (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [6:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       cmd_valid,
	input  logic [1:0] func,
	input  logic [7:0] reg_addr,
	input  logic [7:0] write_data,
	input  logic [3:0] burst_count,
	input  logic       sda_sample,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       scl_level,
	output logic       sda_pull_low,
	output logic       busy_res,
	output logic       read_valid,
	output logic [7:0] read_data,
	output logic       read_last,
	output logic       nak_seen
);

	logic [6:0]       dev_addr_bits_q;
	logic             out_valid_q;
	logic             step_en;
	i2cra_pkg::tick_t tick;
	i2cra_pkg::res_t  res;
	i2cra_pkg::res_t  res_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign step_en   = in_valid && in_ready;

	assign tick.cmd_valid   = cmd_valid;
	assign tick.func        = func;
	assign tick.reg_addr    = reg_addr;
	assign tick.write_data  = write_data;
	assign tick.burst_count = burst_count;
	assign tick.sda_sample  = sda_sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_bits_q <= i2cra_pkg::DEV_ADDR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			dev_addr_bits_q <= cfg_data;
		end
	end

	i2cra_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step_en  (step_en),
		.tick     (tick),
		.dev_addr (dev_addr_bits_q),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_en) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign scl_level    = res_q.scl_level;
	assign sda_pull_low = res_q.sda_pull_low;
	assign busy_res     = res_q.busy_res;
	assign read_valid   = res_q.read_valid;
	assign read_data    = res_q.read_data;
	assign read_last    = res_q.read_last;
	assign nak_seen     = res_q.nak_seen;

endmodule

### hw/rtl/i2cra_core.sv
// Bus sequencer of the I2C register access master: one phase tick per step.
// Depends on i2cra_pkg.
module i2cra_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  i2cra_pkg::tick_t  tick,
	input  logic [6:0]        dev_addr,
	output i2cra_pkg::res_t   res
);

	i2cra_pkg::step_t  step_q, step_e, step_n;
	logic [1:0]        phase_q, phase_e, phase_n;
	logic [3:0]        cnt_q, cnt_n;
	logic [7:0]        shift_q, shift_n;
	i2cra_pkg::burst_t left_q, left_e, left_n, left_dec;
	logic [1:0]        func_q, func_n;
	logic [7:0]        reg_q, reg_n;
	logic [7:0]        data_q, data_n;
	logic              nak_q, nak_e, nak_n;
	logic              take_cmd;
	logic [7:0]        addr_w;

	assign addr_w   = {dev_addr, 1'b0};
	assign take_cmd = (step_q == i2cra_pkg::ST_IDLE) && tick.cmd_valid &&
		(tick.func <= i2cra_pkg::FUNC_BURST);

	// A command taken this tick turns the tick into the first start phase.
	always_comb begin
		step_e  = step_q;
		phase_e = phase_q;
		left_e  = left_q;
		nak_e   = nak_q;
		func_n  = func_q;
		reg_n   = reg_q;
		data_n  = data_q;
		if (take_cmd) begin
			step_e  = i2cra_pkg::ST_START;
			phase_e = 2'd0;
			nak_e   = 1'b0;
			func_n  = tick.func;
			reg_n   = tick.reg_addr;
			data_n  = tick.write_data;
			if (tick.func != i2cra_pkg::FUNC_BURST) begin
				left_e = i2cra_pkg::burst_t'(1);
			end else if (tick.burst_count == 4'd0) begin
				left_e = i2cra_pkg::burst_t'(1);
			end else if (32'(tick.burst_count) > i2cra_pkg::MAX_BURST) begin
				left_e = i2cra_pkg::burst_t'(i2cra_pkg::MAX_BURST);
			end else begin
				left_e = i2cra_pkg::burst_t'(tick.burst_count);
			end
		end
	end

	assign left_dec = (left_e != '0) ? left_e - i2cra_pkg::burst_t'(1) : left_e;

	// Next state.
	always_comb begin
		step_n  = step_e;
		phase_n = phase_e;
		cnt_n   = cnt_q;
		shift_n = shift_q;
		left_n  = left_e;
		nak_n   = nak_e;
		case (step_e)
			i2cra_pkg::ST_IDLE: begin
			end
			i2cra_pkg::ST_START, i2cra_pkg::ST_RESTART: begin
				if (phase_e == 2'd3) begin
					phase_n = 2'd0;
					cnt_n   = 4'd0;
					if (step_e == i2cra_pkg::ST_START) begin
						step_n  = i2cra_pkg::ST_TX_ADDR_W;
						shift_n = addr_w;
					end else begin
						step_n  = i2cra_pkg::ST_TX_ADDR_R;
						shift_n = addr_w | 8'h01;
					end
				end else begin
					phase_n = phase_e + 2'd1;
				end
			end
			i2cra_pkg::ST_TX_ADDR_W, i2cra_pkg::ST_TX_REG,
			i2cra_pkg::ST_TX_DATA, i2cra_pkg::ST_TX_ADDR_R: begin
				if (cnt_q >= i2cra_pkg::DATA_BITS && phase_e == 2'd1 && tick.sda_sample) begin
					nak_n = 1'b1;
				end
				if (phase_e >= 2'd2) begin
					phase_n = 2'd0;
					if (cnt_q < i2cra_pkg::DATA_BITS) begin
						shift_n = {shift_q[6:0], 1'b0};
						cnt_n   = cnt_q + 4'd1;
					end else begin
						case (step_e)
							i2cra_pkg::ST_TX_ADDR_W: begin
								step_n  = i2cra_pkg::ST_TX_REG;
								shift_n = reg_q;
								cnt_n   = 4'd0;
							end
							i2cra_pkg::ST_TX_REG: begin
								if (func_q == i2cra_pkg::FUNC_WRITE) begin
									step_n  = i2cra_pkg::ST_TX_DATA;
									shift_n = data_q;
									cnt_n   = 4'd0;
								end else begin
									step_n = i2cra_pkg::ST_RESTART;
								end
							end
							i2cra_pkg::ST_TX_ADDR_R: begin
								step_n  = i2cra_pkg::ST_RX;
								shift_n = 8'h00;
								cnt_n   = 4'd0;
							end
							default: begin
								step_n = i2cra_pkg::ST_STOP;
							end
						endcase
					end
				end else begin
					phase_n = phase_e + 2'd1;
				end
			end
			i2cra_pkg::ST_RX: begin
				if (cnt_q < i2cra_pkg::DATA_BITS && phase_e == 2'd1) begin
					shift_n = {shift_q[6:0], tick.sda_sample};
				end
				if (phase_e >= 2'd2) begin
					phase_n = 2'd0;
					if (cnt_q < i2cra_pkg::DATA_BITS) begin
						cnt_n = cnt_q + 4'd1;
					end else begin
						left_n = left_dec;
						if (left_dec == '0) begin
							step_n = i2cra_pkg::ST_STOP;
						end else begin
							cnt_n   = 4'd0;
							shift_n = 8'h00;
						end
					end
				end else begin
					phase_n = phase_e + 2'd1;
				end
			end
			i2cra_pkg::ST_STOP: begin
				if (phase_e >= 2'd2) begin
					step_n  = i2cra_pkg::ST_IDLE;
					phase_n = 2'd0;
					cnt_n   = 4'd0;
				end else begin
					phase_n = phase_e + 2'd1;
				end
			end
			default: begin
				step_n  = i2cra_pkg::ST_IDLE;
				phase_n = 2'd0;
				cnt_n   = 4'd0;
			end
		endcase
	end

	// Pin levels and read item of this tick.
	always_comb begin
		res              = '0;
		res.scl_level    = 1'b1;
		res.busy_res     = 1'b1;
		res.nak_seen     = nak_n;
		case (step_e)
			i2cra_pkg::ST_IDLE: begin
				res.busy_res = 1'b0;
			end
			i2cra_pkg::ST_START, i2cra_pkg::ST_RESTART: begin
				res.scl_level    = (phase_e == 2'd1) || (phase_e == 2'd2);
				res.sda_pull_low = (phase_e >= 2'd2);
			end
			i2cra_pkg::ST_TX_ADDR_W, i2cra_pkg::ST_TX_REG,
			i2cra_pkg::ST_TX_DATA, i2cra_pkg::ST_TX_ADDR_R: begin
				res.scl_level = (phase_e == 2'd1);
				if (cnt_q < i2cra_pkg::DATA_BITS) begin
					res.sda_pull_low = !shift_q[7];
				end
			end
			i2cra_pkg::ST_RX: begin
				res.scl_level = (phase_e == 2'd1);
				if (cnt_q < i2cra_pkg::DATA_BITS) begin
					if (phase_e >= 2'd2 && cnt_q == i2cra_pkg::DATA_BITS - 4'd1) begin
						res.read_valid = 1'b1;
						res.read_data  = shift_q;
						res.read_last  = (left_e <= i2cra_pkg::burst_t'(1));
					end
				end else begin
					// Acknowledge every byte but the last one.
					res.sda_pull_low = (left_e > i2cra_pkg::burst_t'(1));
				end
			end
			i2cra_pkg::ST_STOP: begin
				res.scl_level    = (phase_e >= 2'd1);
				res.sda_pull_low = (phase_e < 2'd2);
			end
			default: begin
				res.busy_res = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= i2cra_pkg::ST_IDLE;
			phase_q <= 2'd0;
			cnt_q   <= 4'd0;
			shift_q <= 8'h00;
			left_q  <= '0;
			func_q  <= 2'd0;
			reg_q   <= 8'h00;
			data_q  <= 8'h00;
			nak_q   <= 1'b0;
		end else if (step_en) begin
			step_q  <= step_n;
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			shift_q <= shift_n;
			left_q  <= left_n;
			func_q  <= func_n;
			reg_q   <= reg_n;
			data_q  <= data_n;
			nak_q   <= nak_n;
		end
	end

endmodule

### hw/rtl/i2cra_checker.sv
// Port-level checks of the I2C register access master, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module i2cra_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       scl_level,
	input logic       sda_pull_low,
	input logic       busy_res,
	input logic       read_valid,
	input logic [7:0] read_data,
	input logic       read_last
);

	// An empty output register always lets the next item in.
	`CHK_SAME(a_ready_when_empty, !out_valid, in_ready)
	// A received byte only appears during a command.
	`CHK_SAME(a_read_needs_busy, out_valid && read_valid, busy_res)
	// The last-byte mark only comes with a byte.
	`CHK_SAME(a_last_needs_byte, out_valid && read_last, read_valid)
	// With no command running both lines are released.
	`CHK_SAME(a_idle_released, out_valid && !busy_res, scl_level && !sda_pull_low)
	// A stalled output item holds its byte.
	`CHK_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(read_data))

endmodule

bind i2c_register_access_master i2cra_checker u_i2cra_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.scl_level    (scl_level),
	.sda_pull_low (sda_pull_low),
	.busy_res     (busy_res),
	.read_valid   (read_valid),
	.read_data    (read_data),
	.read_last    (read_last)
);

### tb/tb_i2c_register_access_master.sv
// Self-checking testbench for i2c_register_access_master: every tick is typed in or
// predicted by a bus sequencer cycle model and compared field by field on the output.
// Depends on i2cra_pkg and the RTL of the block; needs nothing else.
module tb_i2c_register_access_master;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned RANDOM_PER_PHASE = 50;
	localparam int unsigned TARGET_PHASES = 3;

	// How the bus answers on SDA while a command runs.
	typedef enum logic [1:0] {
		SDA_LOW,	// every byte acknowledged, read bytes all zero
		SDA_HIGH,	// no acknowledge anywhere, read bytes all ones
		SDA_MIX		// mostly acknowledged, random read bits
	} sda_mode_t;

	typedef struct packed {
		logic            offer;
		logic [1:0]      func;
		logic [7:0]      reg_addr;
		logic [7:0]      data;
		logic [3:0]      count;
		sda_mode_t       sda;
		logic            poke_busy;
		logic            typed;
		i2cra_pkg::res_t first_res;
	} cmd_row_t;

	// Pin levels of a tick, in order scl, pull, busy, read_valid, data, last, nak.
	localparam i2cra_pkg::res_t PINS_IDLE      = '{1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0};
	localparam i2cra_pkg::res_t PINS_IDLE_NAK  = '{1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1};
	localparam i2cra_pkg::res_t PINS_START_ONE = '{1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0};
	localparam i2cra_pkg::res_t PINS_NONE      = '0;

	// Each row offers its command on the first tick if offer is set, then runs the bus
	// until the sequencer is idle again. Only the first tick of a typed row is typed in.
	localparam cmd_row_t DIRECTED [0:9] = '{
		'{1'b0, i2cra_pkg::FUNC_WRITE, 8'h00, 8'h00, 4'd0, SDA_LOW, 1'b0, 1'b1, PINS_IDLE},
		'{1'b1, FUNC_UNUSED, 8'h12, 8'h34, 4'd2, SDA_LOW, 1'b0, 1'b1, PINS_IDLE},
		'{1'b1, i2cra_pkg::FUNC_WRITE, 8'hFF, 8'hFF, 4'd15, SDA_HIGH, 1'b0, 1'b0, PINS_NONE},
		'{1'b1, i2cra_pkg::FUNC_WRITE, 8'h5A, 8'hA5, 4'd1, SDA_MIX, 1'b1, 1'b1,
			PINS_START_ONE},
		'{1'b1, i2cra_pkg::FUNC_READ, 8'hFF, 8'hFF, 4'd8, SDA_HIGH, 1'b0, 1'b0, PINS_NONE},
		'{1'b0, i2cra_pkg::FUNC_WRITE, 8'h00, 8'h00, 4'd0, SDA_LOW, 1'b0, 1'b1, PINS_IDLE_NAK},
		'{1'b1, i2cra_pkg::FUNC_BURST, 8'h10, 8'h00, 4'd0, SDA_MIX, 1'b0, 1'b0, PINS_NONE},
		'{1'b1, i2cra_pkg::FUNC_BURST, 8'h00, 8'hFF, 4'd15, SDA_HIGH, 1'b0, 1'b0, PINS_NONE},
		'{1'b1, FUNC_UNUSED, 8'h00, 8'h00, 4'd0, SDA_LOW, 1'b0, 1'b1, PINS_IDLE_NAK},
		'{1'b1, i2cra_pkg::FUNC_READ, 8'h01, 8'h80, 4'd0, SDA_MIX, 1'b1, 1'b0, PINS_NONE}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [6:0] cfg_data = '0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       cmd_valid = 1'b0;
	logic [1:0] func = '0;
	logic [7:0] reg_addr = '0;
	logic [7:0] write_data = '0;
	logic [3:0] burst_count = '0;
	logic       sda_sample = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       scl_level;
	logic       sda_pull_low;
	logic       busy_res;
	logic       read_valid;
	logic [7:0] read_data;
	logic       read_last;
	logic       nak_seen;

	// Sequencer state as the bus model sees it.
	i2cra_pkg::step_t seq_step = i2cra_pkg::ST_IDLE;
	logic [1:0] bit_ph = '0;
	logic [3:0] bit_cnt = '0;
	logic [7:0] shreg = '0;
	logic [3:0] bytes_rem = '0;
	logic [1:0] cmd_func = '0;
	logic [7:0] cmd_reg = '0;
	logic [7:0] cmd_wdata = '0;
	logic       nak_sticky = 1'b0;
	logic [6:0] target_addr = i2cra_pkg::DEV_ADDR_RESET;

	i2cra_pkg::res_t pins_due [$];
	int unsigned mismatches = 0;
	int unsigned burst_left = 0;
	int unsigned cycle_count = 0;

	i2c_register_access_master dut (.*);

	always #5 clk = ~clk;

	function automatic void load_byte(input i2cra_pkg::step_t s, input logic [7:0] b);
		seq_step = s;
		shreg = b;
		bit_ph = 2'd0;
		bit_cnt = 4'd0;
	endfunction

	// One bus tick: returns the pins of this tick and moves the model on.
	function automatic i2cra_pkg::res_t advance_bus(input i2cra_pkg::tick_t t);
		i2cra_pkg::res_t r;
		logic [7:0]      addr_w;
		logic [3:0]      n;
		r = '0;
		r.scl_level = 1'b1;
		r.busy_res = 1'b1;
		addr_w = {target_addr, 1'b0};
		if (seq_step == i2cra_pkg::ST_IDLE && t.cmd_valid && t.func <= i2cra_pkg::FUNC_BURST)
		begin
			cmd_func = t.func;
			cmd_reg = t.reg_addr;
			cmd_wdata = t.write_data;
			nak_sticky = 1'b0;
			if (t.func == i2cra_pkg::FUNC_BURST) begin
				n = t.burst_count;
				if (n < 1)
					n = 4'd1;
				if (n > i2cra_pkg::MAX_BURST)
					n = 4'(i2cra_pkg::MAX_BURST);
				bytes_rem = n;
			end else begin
				bytes_rem = 4'd1;
			end
			seq_step = i2cra_pkg::ST_START;
			bit_ph = 2'd0;
		end
		case (seq_step)
			i2cra_pkg::ST_IDLE: r.busy_res = 1'b0;
			i2cra_pkg::ST_START, i2cra_pkg::ST_RESTART: begin
				r.scl_level = (bit_ph == 2'd1 || bit_ph == 2'd2);
				r.sda_pull_low = (bit_ph >= 2'd2);
				if (bit_ph == 2'd3) begin
					if (seq_step == i2cra_pkg::ST_START)
						load_byte(i2cra_pkg::ST_TX_ADDR_W, addr_w);
					else
						load_byte(i2cra_pkg::ST_TX_ADDR_R, addr_w | 8'h01);
				end else begin
					bit_ph++;
				end
			end
			i2cra_pkg::ST_TX_ADDR_W, i2cra_pkg::ST_TX_REG,
			i2cra_pkg::ST_TX_DATA, i2cra_pkg::ST_TX_ADDR_R: begin
				r.scl_level = (bit_ph == 2'd1);
				if (bit_cnt < i2cra_pkg::DATA_BITS)
					r.sda_pull_low = !shreg[7];
				else if (bit_ph == 2'd1 && t.sda_sample)
					nak_sticky = 1'b1;
				if (bit_ph >= 2'd2) begin
					bit_ph = 2'd0;
					if (bit_cnt < i2cra_pkg::DATA_BITS) begin
						shreg = shreg << 1;
						bit_cnt++;
					end else begin
						case (seq_step)
							i2cra_pkg::ST_TX_ADDR_W: load_byte(i2cra_pkg::ST_TX_REG, cmd_reg);
							i2cra_pkg::ST_TX_REG: begin
								if (cmd_func == i2cra_pkg::FUNC_WRITE) begin
									load_byte(i2cra_pkg::ST_TX_DATA, cmd_wdata);
								end else begin
									seq_step = i2cra_pkg::ST_RESTART;
									bit_ph = 2'd0;
								end
							end
							i2cra_pkg::ST_TX_ADDR_R: load_byte(i2cra_pkg::ST_RX, 8'h00);
							default: seq_step = i2cra_pkg::ST_STOP;
						endcase
					end
				end else begin
					bit_ph++;
				end
			end
			i2cra_pkg::ST_RX: begin
				r.scl_level = (bit_ph == 2'd1);
				if (bit_cnt < i2cra_pkg::DATA_BITS) begin
					if (bit_ph == 2'd1)
						shreg = {shreg[6:0], t.sda_sample};
					// The byte shows on the last tick of its eighth bit.
					if (bit_ph >= 2'd2 && bit_cnt == i2cra_pkg::DATA_BITS - 4'd1) begin
						r.read_valid = 1'b1;
						r.read_data = shreg;
						r.read_last = (bytes_rem <= 4'd1);
					end
				end else begin
					r.sda_pull_low = (bytes_rem > 4'd1);
				end
				if (bit_ph >= 2'd2) begin
					bit_ph = 2'd0;
					if (bit_cnt < i2cra_pkg::DATA_BITS) begin
						bit_cnt++;
					end else begin
						if (bytes_rem > 4'd0)
							bytes_rem--;
						if (bytes_rem == 4'd0) begin
							seq_step = i2cra_pkg::ST_STOP;
						end else begin
							bit_cnt = 4'd0;
							shreg = 8'h00;
						end
					end
				end else begin
					bit_ph++;
				end
			end
			i2cra_pkg::ST_STOP: begin
				r.scl_level = (bit_ph >= 2'd1);
				r.sda_pull_low = (bit_ph < 2'd2);
				if (bit_ph >= 2'd2) begin
					seq_step = i2cra_pkg::ST_IDLE;
					bit_ph = 2'd0;
					bit_cnt = 4'd0;
				end else begin
					bit_ph++;
				end
			end
			default: begin
				seq_step = i2cra_pkg::ST_IDLE;
				bit_ph = 2'd0;
				bit_cnt = 4'd0;
				r.busy_res = 1'b0;
			end
		endcase
		r.nak_seen = nak_sticky;
		return r;
	endfunction

	// Picks the SDA level for the next tick from where the bus model stands now.
	function automatic logic pick_sda(input sda_mode_t m);
		logic at_ack;
		at_ack = (seq_step inside {i2cra_pkg::ST_TX_ADDR_W, i2cra_pkg::ST_TX_REG,
			i2cra_pkg::ST_TX_DATA, i2cra_pkg::ST_TX_ADDR_R})
			&& bit_cnt == i2cra_pkg::DATA_BITS;
		case (m)
			SDA_LOW: return 1'b0;
			SDA_HIGH: return 1'b1;
			default: return at_ack ? ($urandom_range(7) == 0) : 1'($urandom_range(1));
		endcase
	endfunction

	// Offers one tick in bursts with random gaps; entered and left at a falling edge.
	task automatic drive_tick(input i2cra_pkg::tick_t t, input logic typed,
		input i2cra_pkg::res_t typed_res);
		i2cra_pkg::res_t pred;
		int unsigned     gap;
		if (burst_left == 0) begin
			gap = $urandom_range(6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(4) == 0) ? $urandom_range(300, 100)
				: $urandom_range(12, 1);
		end
		burst_left--;
		in_valid <= 1'b1;
		{cmd_valid, func, reg_addr, write_data, burst_count, sda_sample} <= t;
		do @(posedge clk); while (!in_ready);
		pred = advance_bus(t);
		pins_due.push_back(typed ? typed_res : pred);
		@(negedge clk);
	endtask

	// The target address changes only with the sequencer idle and no item in flight.
	task automatic write_target(input logic [6:0] a);
		in_valid <= 1'b0;
		while (pins_due.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= a;
		do @(posedge clk); while (!cfg_ready);
		target_addr = a;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	initial begin : stimulus
		cmd_row_t         row;
		i2cra_pkg::tick_t t;
		int unsigned      n;
		int unsigned      ph;
		int unsigned      w;
		logic [6:0]       addr;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < $size(DIRECTED); i++) begin
			row = DIRECTED[i];
			t = 24'($urandom);
			t.cmd_valid = row.offer;
			t.func = row.func;
			t.reg_addr = row.reg_addr;
			t.write_data = row.data;
			t.burst_count = row.count;
			t.sda_sample = pick_sda(row.sda);
			drive_tick(t, row.typed, row.first_res);
			while (seq_step != i2cra_pkg::ST_IDLE) begin
				t = 24'($urandom);
				t.cmd_valid = row.poke_busy;
				t.sda_sample = pick_sda(row.sda);
				drive_tick(t, 1'b0, PINS_NONE);
			end
		end

		for (ph = 0; ph < TARGET_PHASES; ph++) begin
			addr = (ph == 0) ? 7'h00 : (ph == 1) ? 7'h7F : 7'($urandom);
			write_target(addr);
			n = 0;
			while (n < RANDOM_PER_PHASE || seq_step != i2cra_pkg::ST_IDLE) begin
				t = 24'($urandom);
				if (seq_step == i2cra_pkg::ST_IDLE) begin
					t.cmd_valid = ($urandom_range(9) != 0);
					if (t.func == FUNC_UNUSED && $urandom_range(3) != 0)
						t.func = 2'($urandom_range(2));
					// Short bursts keep the commands quick; the raw value still
					// reaches the clamped counts now and then.
					if ($urandom_range(3) != 0)
						t.burst_count = 4'($urandom_range(4, 1));
				end else begin
					t.cmd_valid = ($urandom_range(7) == 0);
				end
				t.sda_sample = pick_sda(SDA_MIX);
				drive_tick(t, 1'b0, PINS_NONE);
				n++;
			end
		end

		in_valid <= 1'b0;
		for (w = 0; w < 5000 && pins_due.size() != 0; w++) @(negedge clk);
		if (pins_due.size() != 0) begin
			$error("%0d output items never arrived", pins_due.size());
			mismatches++;
		end
		repeat (10) @(negedge clk);
		if (mismatches == 0)
			$display("tb_i2c_register_access_master passed");
		else
			$display("tb_i2c_register_access_master failed");
		$finish;
	end

	// Receiver: segments of varying stall rate, and now and then a long hold-off
	// that fills the output register and pushes back on the sender.
	initial begin : rx_stall
		int unsigned seg_no;
		int unsigned seg_len;
		int unsigned stall_pct;
		seg_no = 0;
		@(negedge clk);
		forever begin
			seg_no++;
			if (seg_no % 16 == 4) begin
				out_ready <= 1'b0;
				repeat (150) @(negedge clk);
			end else begin
				stall_pct = $urandom_range(2) * 30;
				seg_len = $urandom_range(80, 10);
				repeat (seg_len) begin
					out_ready <= ($urandom_range(99) >= stall_pct);
					@(negedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin : out_check
		i2cra_pkg::res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pins_due.size() == 0) begin
				$error("output item with none expected");
				mismatches++;
			end else begin
				want = pins_due.pop_front();
				check_field("scl_level", 8'(want.scl_level), 8'(scl_level));
				check_field("sda_pull_low", 8'(want.sda_pull_low), 8'(sda_pull_low));
				check_field("busy_res", 8'(want.busy_res), 8'(busy_res));
				check_field("read_valid", 8'(want.read_valid), 8'(read_valid));
				check_field("read_data", want.read_data, read_data);
				check_field("read_last", 8'(want.read_last), 8'(read_last));
				check_field("nak_seen", 8'(want.nak_seen), 8'(nak_seen));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_i2c_register_access_master failed");
			$finish;
		end
	end

endmodule
